// File: src/imdu_pkg.sv
// Shared types and constants for the 128-bit multiply/divide unit.
package imdu_pkg;

  // Operand and result width, and the width of the bit-position counter.
  localparam int W     = 128;
  localparam int HALF  = W / 2;
  localparam int CNT_W = $clog2(W);

  // Operation codes carried in the mode field.
  localparam logic [2:0] MODE_UDIV = 3'd0;
  localparam logic [2:0] MODE_UMOD = 3'd1;
  localparam logic [2:0] MODE_SDIV = 3'd2;
  localparam logic [2:0] MODE_SMOD = 3'd3;
  localparam logic [2:0] MODE_MUL  = 3'd4;

  // Which register the final pass sends to the result.
  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_QUO  = 2'd1,
    RES_ACC  = 2'd2
  } res_sel_t;

  // Per-cycle commands from the sequencer to the datapath.
  typedef struct packed {
    logic     load;
    logic     neg_a;
    logic     neg_b;
    logic     step;
    logic     is_mul;
    logic     fin;
    res_sel_t res_sel;
    logic     res_neg;
  } dp_ctrl_t;

endpackage

// File: src/int128_mul_div_unit_top.sv
// Top level of the 128-bit multiply/divide unit.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+------------------------------------------
//   input   | in_valid, in_stall  | mode, first_hi, first_lo, second_hi,
//           |                     | second_lo
//   output  | out_valid, out_stall| result_hi, result_lo, zero_divisor
//
// One item at a time. Unsigned and multiply items go from the transfer to the
// loop state, one bit position per cycle through the shared 128-bit adder,
// then to the result state. Signed items first pass S_NEGA and S_NEGB to form
// operand magnitudes; the final sign fix shares the result cycle. Zero
// divisors and unused modes go straight from the transfer to the result state.
// Reset is synchronous on rst and clears the sequencer and output valid.
// A stalled result holds in the output register; the next item is accepted
// meanwhile and waits in its result cycle until the register frees.
module int128_mul_div_unit_top import imdu_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [2:0]      mode,
  input  logic [HALF-1:0] first_hi,
  input  logic [HALF-1:0] first_lo,
  input  logic [HALF-1:0] second_hi,
  input  logic [HALF-1:0] second_lo,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [HALF-1:0] result_hi,
  output logic [HALF-1:0] result_lo,
  output logic            zero_divisor
);

  dp_ctrl_t ctrl;
  logic     second_zero;

  assign second_zero = (second_hi == '0) && (second_lo == '0);

  // Sequencer.
  imdu_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .first_sign   (first_hi[HALF-1]),
    .second_sign  (second_hi[HALF-1]),
    .second_zero  (second_zero),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .zero_divisor (zero_divisor),
    .ctrl         (ctrl)
  );

  // Shared arithmetic datapath.
  imdu_datapath u_datapath (
    .clk       (clk),
    .ctrl      (ctrl),
    .first_hi  (first_hi),
    .first_lo  (first_lo),
    .second_hi (second_hi),
    .second_lo (second_lo),
    .result_hi (result_hi),
    .result_lo (result_lo)
  );

endmodule

// File: src/imdu_datapath.sv
// Datapath: operand registers around one shared 128-bit add/subtract unit.
module imdu_datapath import imdu_pkg::*; (
  input  logic            clk,
  input  dp_ctrl_t        ctrl,
  input  logic [HALF-1:0] first_hi,
  input  logic [HALF-1:0] first_lo,
  input  logic [HALF-1:0] second_hi,
  input  logic [HALF-1:0] second_lo,
  output logic [HALF-1:0] result_hi,
  output logic [HALF-1:0] result_lo
);

  // acc: partial remainder or product; quo: dividend/quotient or multiplier;
  // dvs: divisor or multiplicand.
  logic [W-1:0] acc;
  logic [W-1:0] quo;
  logic [W-1:0] dvs;
  logic [W-1:0] acc_sh;
  logic [W-1:0] opa;
  logic [W-1:0] opb;
  logic         sub;
  logic [W:0]   sum;
  logic         take;

  // Remainder shifts left taking the next dividend bit; product just doubles.
  assign acc_sh = {acc[W-2:0], ctrl.is_mul ? 1'b0 : quo[W-1]};

  // Operand selection for the shared adder.
  always_comb begin
    opa = acc_sh;
    opb = dvs;
    sub = 1'b0;
    if (ctrl.neg_a) begin
      opa = '0;
      opb = quo;
      sub = 1'b1;
    end else if (ctrl.neg_b) begin
      opa = '0;
      opb = dvs;
      sub = 1'b1;
    end else if (ctrl.step) begin
      opa = acc_sh;
      opb = (ctrl.is_mul && !quo[W-1]) ? '0 : dvs;
      sub = !ctrl.is_mul;
    end else if (ctrl.fin) begin
      opa = '0;
      case (ctrl.res_sel)
        RES_QUO: opb = quo;
        RES_ACC: opb = acc;
        default: opb = '0;
      endcase
      sub = ctrl.res_neg;
    end
  end

  // The shared unit: a + b, or a - b as a + ~b + 1 with carry meaning no borrow.
  assign sum = {1'b0, opa} + {1'b0, sub ? ~opb : opb} + {{W{1'b0}}, sub};

  // Subtract when the shifted remainder overflowed or is not below the divisor.
  assign take = acc[W-1] | sum[W];

  // Working registers.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc <= '0;
      quo <= {first_hi, first_lo};
      dvs <= {second_hi, second_lo};
    end else if (ctrl.neg_a) begin
      quo <= sum[W-1:0];
    end else if (ctrl.neg_b) begin
      dvs <= sum[W-1:0];
    end else if (ctrl.step) begin
      if (ctrl.is_mul) begin
        acc <= sum[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end else begin
        acc <= take ? sum[W-1:0] : acc_sh;
        quo <= {quo[W-2:0], take};
      end
    end
  end

  // Output register, loaded on the final pass.
  always_ff @(posedge clk) begin
    if (ctrl.fin) begin
      result_hi <= sum[W-1:HALF];
      result_lo <= sum[HALF-1:0];
    end
  end

endmodule

// File: src/imdu_ctrl.sv
// Sequencer: steps the datapath through sign fixup, bit loop and result.
module imdu_ctrl import imdu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic [2:0] mode,
  input  logic     first_sign,
  input  logic     second_sign,
  input  logic     second_zero,
  output logic     out_valid,
  input  logic     out_stall,
  output logic     zero_divisor,
  output dp_ctrl_t ctrl
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_NEGA = 5'b00010,
    S_NEGB = 5'b00100,
    S_LOOP = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [CNT_W-1:0] cnt;
  logic [2:0] mode_q;
  logic       sa;
  logic       sb;
  logic       zdiv;
  res_sel_t   res_sel;
  res_sel_t   res_sel_in;
  logic       accept;
  logic       out_free;
  logic       div_zero;
  logic       bad_mode;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign div_zero = second_zero && (mode <= MODE_SMOD);
  assign bad_mode = (mode > MODE_MUL);

  // Pick the result source for the incoming item.
  always_comb begin
    if (div_zero || bad_mode) begin
      res_sel_in = RES_ZERO;
    end else begin
      case (mode) inside
        MODE_UDIV, MODE_SDIV: res_sel_in = RES_QUO;
        default:              res_sel_in = RES_ACC;
      endcase
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (div_zero || bad_mode) begin
            state_next = S_FIN;
          end else if (mode == MODE_SDIV || mode == MODE_SMOD) begin
            state_next = S_NEGA;
          end else begin
            state_next = S_LOOP;
          end
        end
      end
      S_NEGA: state_next = S_NEGB;
      S_NEGB: state_next = S_LOOP;
      S_LOOP: begin
        if (cnt == CNT_W'(W - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    ctrl.load    = accept;
    ctrl.neg_a   = (state == S_NEGA) && sa;
    ctrl.neg_b   = (state == S_NEGB) && sb;
    ctrl.step    = (state == S_LOOP);
    ctrl.is_mul  = (mode_q == MODE_MUL);
    ctrl.fin     = (state == S_FIN) && out_free;
    ctrl.res_sel = res_sel;
    ctrl.res_neg = ((mode_q == MODE_SDIV) && (sa != sb)) || ((mode_q == MODE_SMOD) && sa);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_LOOP) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
      if (ctrl.fin) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item attributes captured with the transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q  <= mode;
      sa      <= first_sign;
      sb      <= second_sign;
      zdiv    <= div_zero;
      res_sel <= res_sel_in;
    end
    if (ctrl.fin) begin
      zero_divisor <= zdiv;
    end
  end

endmodule

// File: src/imdu_checker.sv
// Port-level assertions for the multiply/divide unit, bound to the top level.
module imdu_checker import imdu_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic [HALF-1:0] result_hi,
  input logic [HALF-1:0] result_lo,
  input logic            zero_divisor
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(result_hi) && $stable(result_lo)
      && $stable(zero_divisor))
    else $error("result changed while stalled");

  // The unit is busy right after taking an item.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transfer taken while busy");

  // No result can be ready in the cycle after a transfer.
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

  // A zero-divisor result is zero.
  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_divisor |-> (result_hi == '0) && (result_lo == '0))
    else $error("zero divisor with nonzero result");

endmodule

bind int128_mul_div_unit_top imdu_checker u_imdu_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .result_hi    (result_hi),
  .result_lo    (result_lo),
  .zero_divisor (zero_divisor)
);

// File: tb/tb_top.sv
// Self-checking testbench for the 128-bit multiply/divide unit.
`timescale 1ns / 100ps

module tb_top;
  import imdu_pkg::*;

  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int RANDOM_OPS       = 1400;
  localparam int MAX_IDLE         = 11;
  localparam int LONG_HOLD_CYCLES = 700;
  localparam int PRESSURE_AT      = 400;
  localparam int DRAIN_CYCLES     = 150;
  localparam int MAX_REPORTS      = 100;

  // Mode codes the block leaves unused; they must return all zeros.
  localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;

  localparam logic [2:0] ARITH_MODES [5] = '{MODE_UDIV, MODE_UMOD, MODE_SDIV,
                                             MODE_SMOD, MODE_MUL};

  // Signed extremes of a 128-bit operand.
  localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] ALL_ONES = {W{1'b1}};

  // Operand values that exercise sign handling and wraparound.
  localparam int CORNER_COUNT = 7;
  localparam logic [W-1:0] CORNERS [CORNER_COUNT] = '{
    {W{1'b0}}, {{(W-1){1'b0}}, 1'b1}, {{(W-3){1'b0}}, 3'b111},
    {{(W-3){1'b1}}, 3'b001}, MAX_POS, MIN_NEG, ALL_ONES};

  typedef struct packed {
    logic [2:0]      mode;
    logic [HALF-1:0] first_hi;
    logic [HALF-1:0] first_lo;
    logic [HALF-1:0] second_hi;
    logic [HALF-1:0] second_lo;
  } op_t;

  typedef struct packed {
    logic [2:0]      mode;
    logic [HALF-1:0] hi;
    logic [HALF-1:0] lo;
    logic            zdiv;
  } outcome_t;

  // Predicts quotient, remainder or product for each operand transfer and
  // compares every result transfer against the oldest prediction.
  class result_checker;
    outcome_t pending_results[$];
    int n_checked;
    int n_errors;
    int n_div;
    int n_mod;
    int n_mul;
    int n_zero_div;
    int n_unused;

    function outcome_t arith_result(op_t op);
      logic [W-1:0] a;
      logic [W-1:0] b;
      logic [W-1:0] mag_a;
      logic [W-1:0] mag_b;
      logic [W-1:0] quo;
      logic [W-1:0] rem;
      logic [W-1:0] res;
      logic         signed_op;
      logic         neg_a;
      logic         neg_b;
      outcome_t     o;
      a = {op.first_hi, op.first_lo};
      b = {op.second_hi, op.second_lo};
      res = '0;
      o.zdiv = 1'b0;
      o.mode = op.mode;
      if (op.mode == MODE_MUL) begin
        res = a * b;
      end else if (op.mode == MODE_UDIV || op.mode == MODE_UMOD ||
                   op.mode == MODE_SDIV || op.mode == MODE_SMOD) begin
        if (b == '0) begin
          o.zdiv = 1'b1;
        end else begin
          // Signed modes divide magnitudes; -2^127 keeps its bits as 2^127.
          signed_op = (op.mode == MODE_SDIV || op.mode == MODE_SMOD);
          neg_a = signed_op & a[W-1];
          neg_b = signed_op & b[W-1];
          mag_a = neg_a ? -a : a;
          mag_b = neg_b ? -b : b;
          quo = mag_a / mag_b;
          rem = mag_a % mag_b;
          if (op.mode == MODE_UDIV) res = quo;
          else if (op.mode == MODE_UMOD) res = rem;
          else if (op.mode == MODE_SDIV) res = (neg_a ^ neg_b) ? -quo : quo;
          else res = neg_a ? -rem : rem;
        end
      end
      o.hi = res[W-1:HALF];
      o.lo = res[HALF-1:0];
      return o;
    endfunction

    function void record_operands(op_t op);
      outcome_t o;
      o = arith_result(op);
      pending_results.push_back(o);
      if (o.zdiv) n_zero_div++;
      else if (op.mode == MODE_UDIV || op.mode == MODE_SDIV) n_div++;
      else if (op.mode == MODE_UMOD || op.mode == MODE_SMOD) n_mod++;
      else if (op.mode == MODE_MUL) n_mul++;
      else n_unused++;
    endfunction

    function void report(string field, logic [HALF-1:0] want, logic [HALF-1:0] got,
                         logic [2:0] m);
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%0t: mode %0d %s mismatch: expected %h, actual %h",
                 $time, m, field, want, got);
      else if (n_errors == MAX_REPORTS + 1)
        $display("%0t: further mismatches not shown", $time);
    endfunction

    function void check_result(logic [HALF-1:0] hi, logic [HALF-1:0] lo, logic zdiv);
      outcome_t want;
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: result transfer with none expected: hi %h lo %h zero_divisor %b",
                   $time, hi, lo, zdiv);
        return;
      end
      want = pending_results.pop_front();
      n_checked++;
      if (hi !== want.hi) report("result_hi", want.hi, hi, want.mode);
      if (lo !== want.lo) report("result_lo", want.lo, lo, want.mode);
      if (zdiv !== want.zdiv) report("zero_divisor", HALF'(want.zdiv), HALF'(zdiv), want.mode);
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid;
  logic            in_stall;
  logic [2:0]      mode;
  logic [HALF-1:0] first_hi;
  logic [HALF-1:0] first_lo;
  logic [HALF-1:0] second_hi;
  logic [HALF-1:0] second_lo;
  logic            out_valid;
  logic            out_stall;
  logic [HALF-1:0] result_hi;
  logic [HALF-1:0] result_lo;
  logic            zero_divisor;
  logic            recv_stall = 1'b1;
  logic            hold_off = 1'b0;
  int              n_sent = 0;
  int              cycle_count = 0;

  // When set, both sides offer and take transfers without idle cycles.
  bit no_idle = 1'b1;

  result_checker board = new();

  int128_mul_div_unit_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .first_hi     (first_hi),
    .first_lo     (first_lo),
    .second_hi    (second_hi),
    .second_lo    (second_lo),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_hi    (result_hi),
    .result_lo    (result_lo),
    .zero_divisor (zero_divisor)
  );

  // Free-running clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver's own idling and the long hold both stall the output.
  assign out_stall = recv_stall | hold_off;

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        board.record_operands({mode, first_hi, first_lo, second_hi, second_lo});
      if (out_valid && !out_stall)
        board.check_result(result_hi, result_lo, zero_divisor);
    end
  end

  // Stop a run that no longer makes progress.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d results outstanding",
               $time, board.pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic op_t make_op(logic [2:0] m, logic [W-1:0] a, logic [W-1:0] b);
    op_t op;
    op.mode      = m;
    op.first_hi  = a[W-1:HALF];
    op.first_lo  = a[HALF-1:0];
    op.second_hi = b[W-1:HALF];
    op.second_lo = b[HALF-1:0];
    return op;
  endfunction

  // Random operand with a mix of magnitudes, small signed values and corners.
  function automatic logic [W-1:0] rand_operand();
    logic [W-1:0] v;
    int           kind;
    v = {$urandom, $urandom, $urandom, $urandom};
    kind = $urandom_range(5, 0);
    case (kind)
      0: v = v >> $urandom_range(W - 1, 0);
      1: v = W'(v[15:0]);
      2: v = -W'(v[15:0]);
      3: v = CORNERS[$urandom_range(CORNER_COUNT - 1, 0)];
      default: v = v;
    endcase
    return v;
  endfunction

  function automatic op_t random_op();
    logic [2:0]   m;
    logic [W-1:0] a;
    logic [W-1:0] b;
    if ($urandom_range(19, 0) == 0)
      m = 3'($urandom_range(MODE_UNUSED_LAST, MODE_UNUSED_FIRST));
    else
      m = ARITH_MODES[$urandom_range(4, 0)];
    a = rand_operand();
    b = rand_operand();
    if ($urandom_range(15, 0) == 0) b = '0;
    return make_op(m, a, b);
  endfunction

  // Sender side: idle gap, then hold the item until the block takes it.
  task automatic send_op(op_t op);
    int gap;
    gap = no_idle ? 0 : $urandom_range(MAX_IDLE, 0);
    repeat (gap) @(negedge clk);
    in_valid  = 1'b1;
    mode      = op.mode;
    first_hi  = op.first_hi;
    first_lo  = op.first_lo;
    second_hi = op.second_hi;
    second_lo = op.second_lo;
    do begin
      @(posedge clk);
    end while (in_stall);
    n_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Every mode against every pair of corner operands, plus the unused modes.
  task automatic run_directed();
    for (int m = 0; m < 5; m++) begin
      for (int i = 0; i < CORNER_COUNT; i++) begin
        for (int j = 0; j < CORNER_COUNT; j++) begin
          send_op(make_op(ARITH_MODES[m], CORNERS[i], CORNERS[j]));
        end
      end
    end
    for (int u = int'(MODE_UNUSED_FIRST); u <= int'(MODE_UNUSED_LAST); u++) begin
      send_op(make_op(3'(u), MAX_POS, CORNERS[2]));
      send_op(make_op(3'(u), MIN_NEG, '0));
    end
  endtask

  // Receiver side: idle for a drawn number of cycles, then take one result.
  initial begin : receiver
    int gap;
    recv_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(MAX_IDLE, 0);
      if (gap > 0) begin
        recv_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      recv_stall = 1'b0;
      do begin
        @(posedge clk);
      end while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  // Long output stall while the sender keeps offering items.
  initial begin : pressure
    wait (n_sent >= PRESSURE_AT);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (LONG_HOLD_CYCLES) @(negedge clk);
    hold_off = 1'b0;
  end

  // Reset, directed corners back to back, then random traffic with idling.
  initial begin : main
    in_valid  = 1'b0;
    mode      = '0;
    first_hi  = '0;
    first_lo  = '0;
    second_hi = '0;
    second_lo = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    no_idle = 1'b1;
    run_directed();
    no_idle = 1'b0;
    for (int i = 0; i < RANDOM_OPS; i++) begin
      send_op(random_op());
    end

    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items: %0d quotients, %0d remainders, %0d products,",
             n_sent, board.n_div, board.n_mod, board.n_mul);
    $display("%0d zero divisors and %0d unused modes, with a long output stall.",
             board.n_zero_div, board.n_unused);
    if (board.n_errors == 0 && board.n_checked == n_sent)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: files.f
src/imdu_pkg.sv
src/imdu_datapath.sv
src/imdu_ctrl.sv
src/int128_mul_div_unit_top.sv
src/imdu_checker.sv
tb/tb_top.sv
